@@ hw/rtl/rational_iterative_sqrt_one_plus_x_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rational square root block
// Concurrent checks, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ITERATIVE_SQRT_ONE_PLUS_X_DEFINES_SVH
`define RATIONAL_ITERATIVE_SQRT_ONE_PLUS_X_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsq assertion failed");

`endif

@@ hw/rtl/rsq_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational square root package
// Types, widths, constants and saturating helpers shared by all modules.
// ----------------------------------------------------------------------------
package rsq_pkg;

    localparam int FRAC_BITS      = 24;
    localparam int MAX_ITERATIONS = 8;
    localparam int SAT_EXP        = 61;
    localparam int WORD_W         = SAT_EXP + 2;
    localparam int MAG_W          = SAT_EXP + 1;
    localparam int CFG_W          = 4;
    localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
    localparam int DIVD_W         = MAG_W + FRAC_BITS + 1;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [MAG_W-1:0]         mag_t;

    localparam word_t SAT_LIMIT = word_t'(64'sd1 <<< SAT_EXP);
    localparam word_t ONE       = word_t'(64'sd1 <<< FRAC_BITS);
    localparam word_t ONE_X4    = ONE * word_t'(4);
    localparam word_t ONE_X64   = ONE * word_t'(64);
    localparam word_t RES_MAX   = word_t'(64'sd2147483647);
    localparam word_t RES_MIN   = -word_t'(64'sd2147483648);
    localparam word_t B_MAX     = word_t'(64'sd2147483647);

    localparam word_t C3   = word_t'(3);
    localparam word_t C7   = word_t'(7);
    localparam word_t C24  = word_t'(24);
    localparam word_t C56  = word_t'(56);
    localparam word_t C80  = word_t'(80);
    localparam word_t C112 = word_t'(112);

    localparam word_t LIM3   = SAT_LIMIT / C3;
    localparam word_t LIM7   = SAT_LIMIT / C7;
    localparam word_t LIM24  = SAT_LIMIT / C24;
    localparam word_t LIM56  = SAT_LIMIT / C56;
    localparam word_t LIM80  = SAT_LIMIT / C80;
    localparam word_t LIM112 = SAT_LIMIT / C112;

    localparam logic [1:0] MUL_SEL_AA  = 2'd0;
    localparam logic [1:0] MUL_SEL_A2A = 2'd1;
    localparam logic [1:0] MUL_SEL_BF  = 2'd2;
    localparam logic [1:0] MUL_SEL_FF  = 2'd3;

    localparam logic DIV_SEL_FACT = 1'b0;
    localparam logic DIV_SEL_S    = 1'b1;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic               degree_select;
    } in_t;

    typedef struct packed {
        logic [2:0]         iteration_index;
        logic [30:0]        approximation;
        logic signed [31:0] residual;
        logic               last_result;
        logic               domain_error;
    } out_t;

    typedef struct packed {
        logic       load_item;
        logic       iter_next;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       div_start;
        logic       div_sel;
        logic       lat_a2;
        logic       lat_a3;
        logic       lat_fac;
        logic       lat_f;
        logic       lat_b;
        logic       lat_f2;
        logic       lat_a;
        logic       out_load;
        logic       out_error;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic x_error;
        logic cubic;
        logic last;
    } status_t;

    function automatic word_t sat_add(input word_t p, input word_t q);
        logic signed [WORD_W:0] s;
        s = (WORD_W+1)'(p) + (WORD_W+1)'(q);
        if (s > (WORD_W+1)'(SAT_LIMIT))
            return SAT_LIMIT;
        if (s < -(WORD_W+1)'(SAT_LIMIT))
            return -SAT_LIMIT;
        return word_t'(s);
    endfunction

    function automatic word_t sat_scale(input word_t v, input word_t c, input word_t lim);
        if (v > lim)
            return SAT_LIMIT;
        if (v < -lim)
            return -SAT_LIMIT;
        return v * c;
    endfunction

endpackage

@@ hw/rtl/rsq_mul.sv @@
// ----------------------------------------------------------------------------
// Rational square root multiplier
// Signed fixed-point product from four 32 by 32 partial products, rounded
// to nearest with ties away from zero and saturated.
// ----------------------------------------------------------------------------
module rsq_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rsq_pkg::word_t op_p,
    input  rsq_pkg::word_t op_q,
    output logic          done,
    output rsq_pkg::word_t result
);
    import rsq_pkg::*;

    localparam int ACC_W       = 2 * MAG_W;
    localparam int MUL_OVF_BIT = 64 + FRAC_BITS - 3;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [1:0]       step_reg, step_next;
    mag_t             mag_p_reg, mag_q_reg;
    logic             neg_reg;
    logic [ACC_W-1:0] acc_reg, acc_next;
    word_t            abs_p, abs_q;
    logic [31:0]      half_p, half_q;
    logic [63:0]      pp;
    logic [ACC_W-1:0] pp_shifted;
    logic [ACC_W:0]   rounded;
    logic [ACC_W:0]   shifted;
    logic             ovf;
    word_t            mag_res;

    assign abs_p = op_p[WORD_W-1] ? -op_p : op_p;
    assign abs_q = op_q[WORD_W-1] ? -op_q : op_q;

    always_comb
    begin
        half_p = 32'(mag_p_reg);
        half_q = 32'(mag_q_reg);
        pp_shifted = '0;
        case (step_reg)
            2'd0:
            begin
                half_p = 32'(mag_p_reg);
                half_q = 32'(mag_q_reg);
            end
            2'd1:
            begin
                half_p = 32'(mag_p_reg);
                half_q = 32'(mag_q_reg >> 32);
            end
            2'd2:
            begin
                half_p = 32'(mag_p_reg >> 32);
                half_q = 32'(mag_q_reg);
            end
            default:
            begin
                half_p = 32'(mag_p_reg >> 32);
                half_q = 32'(mag_q_reg >> 32);
            end
        endcase
        pp = 64'(half_p) * 64'(half_q);
        case (step_reg)
            2'd0:    pp_shifted = ACC_W'(pp);
            2'd1:    pp_shifted = ACC_W'(pp) << 32;
            2'd2:    pp_shifted = ACC_W'(pp) << 32;
            default: pp_shifted = ACC_W'(pp) << 64;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + pp_shifted;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            mag_p_reg <= MAG_W'(abs_p);
            mag_q_reg <= MAG_W'(abs_q);
            neg_reg   <= op_p[WORD_W-1] ^ op_q[WORD_W-1];
        end
    end

    always_comb
    begin
        rounded = (ACC_W+1)'(acc_reg) + ((ACC_W+1)'(1) << (FRAC_BITS - 1));
        ovf     = |rounded[ACC_W:MUL_OVF_BIT];
        shifted = rounded >> FRAC_BITS;
        if (ovf || (shifted > (ACC_W+1)'(SAT_LIMIT)))
            mag_res = SAT_LIMIT;
        else
            mag_res = word_t'(shifted);
        result = neg_reg ? -mag_res : mag_res;
    end

    assign done = done_reg;

endmodule

@@ hw/rtl/rsq_div.sv @@
// ----------------------------------------------------------------------------
// Rational square root divider
// Restoring divider, one quotient bit per cycle, giving n/d in fixed point
// rounded to nearest with ties up and saturated.
// ----------------------------------------------------------------------------
module rsq_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rsq_pkg::mag_t  num,
    input  rsq_pkg::mag_t  den,
    output logic           done,
    output rsq_pkg::word_t result
);
    import rsq_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);
    localparam mag_t Q0_LIM = MAG_W'(SAT_LIMIT >>> FRAC_BITS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVD_W-1:0] qd_reg, qd_next;
    mag_t              rem_reg, rem_next;
    mag_t              den_reg;
    logic [MAG_W:0]    rem_shift;
    logic              fits;
    mag_t              q0;
    logic [DIVD_W:0]   q_inc;
    logic [DIVD_W-1:0] half;

    assign rem_shift = {rem_reg, qd_reg[DIVD_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        qd_next   = qd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            qd_next   = {num, {(FRAC_BITS + 1){1'b0}}};
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? MAG_W'(rem_shift - {1'b0, den_reg}) : MAG_W'(rem_shift);
            qd_next  = {qd_reg[DIVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qd_reg  <= qd_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end

    always_comb
    begin
        q0    = qd_reg[DIVD_W-1:FRAC_BITS+1];
        q_inc = (DIVD_W+1)'(qd_reg) + 1'b1;
        half  = q_inc[DIVD_W:1];
        if ((q0 > Q0_LIM) || (half > DIVD_W'(SAT_LIMIT)))
            result = SAT_LIMIT;
        else
            result = word_t'(half);
    end

    assign done = done_reg;

endmodule

@@ hw/rtl/rsq_datapath.sv @@
// ----------------------------------------------------------------------------
// Rational square root datapath
// Holds the residual, product and factor terms, the iteration count and
// the result register, and drives the shared multiplier and divider.
// ----------------------------------------------------------------------------
module rsq_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_enable,
    input  logic [3:0]        cfg_write_data,
    input  rsq_pkg::in_t      in_data,
    input  rsq_pkg::cmd_t     cmd,
    output rsq_pkg::status_t  status,
    output rsq_pkg::out_t     out_data
);
    import rsq_pkg::*;

    logic [CFG_W-1:0]   cfg_count_reg;
    logic [ITER_W-1:0]  n_reg, k_reg, n_clamped;
    logic               cubic_reg;
    logic signed [31:0] a_reg;
    logic [30:0]        b_reg;
    word_t              a2_reg, a3_reg, f_reg, f2_reg;
    word_t              t1_reg, t2_reg, d1_reg, d2_reg;
    word_t              t1_next, t2_next, d1_next, d2_next;
    out_t               out_reg;
    word_t              a_w, b_w, num_s, den_s, s_w, an_w;
    mag_t               div_num, div_den;
    word_t              mul_p, mul_q, mul_result, div_result;
    logic               mul_done, div_done;
    logic signed [31:0] a_new;
    logic [30:0]        b_new;
    word_t              f2_new;

    assign a_w = word_t'(a_reg);
    assign b_w = word_t'(b_reg);

    always_comb
    begin
        if (cfg_count_reg == '0)
            n_clamped = ITER_W'(1);
        else if (ITER_W'(cfg_count_reg) > ITER_W'(MAX_ITERATIONS))
            n_clamped = ITER_W'(MAX_ITERATIONS);
        else
            n_clamped = ITER_W'(cfg_count_reg);
    end

    always_comb
    begin
        mul_p = a_w;
        mul_q = a_w;
        case (cmd.mul_sel)
            MUL_SEL_AA:
            begin
                mul_p = a_w;
                mul_q = a_w;
            end
            MUL_SEL_A2A:
            begin
                mul_p = a2_reg;
                mul_q = a_w;
            end
            MUL_SEL_BF:
            begin
                mul_p = b_w;
                mul_q = f_reg;
            end
            default:
            begin
                mul_p = f_reg;
                mul_q = f_reg;
            end
        endcase
    end

    always_comb
    begin
        if (cubic_reg)
        begin
            t1_next = sat_add(sat_scale(a3_reg, C7, LIM7), sat_scale(a2_reg, C56, LIM56));
            t2_next = sat_add(sat_scale(a_w, C112, LIM112), ONE_X64);
            d1_next = sat_add(a3_reg, sat_scale(a2_reg, C24, LIM24));
            d2_next = sat_add(sat_scale(a_w, C80, LIM80), ONE_X64);
        end
        else
        begin
            t1_next = sat_scale(a_w, C3, LIM3);
            t2_next = ONE_X4;
            d1_next = a_w;
            d2_next = ONE_X4;
        end
    end

    always_comb
    begin
        num_s = sat_add(t1_reg, t2_reg);
        den_s = sat_add(d1_reg, d2_reg);
        s_w   = ONE + a_w;
        if (cmd.div_sel == DIV_SEL_FACT)
        begin
            div_num = (num_s < 0) ? '0 : MAG_W'(num_s);
            div_den = (den_s <= 0) ? MAG_W'(1) : MAG_W'(den_s);
        end
        else
        begin
            div_num = (s_w < 0) ? '0 : MAG_W'(s_w);
            div_den = MAG_W'(f2_reg);
        end
    end

    always_comb
    begin
        if (mul_result > B_MAX)
            b_new = 31'(B_MAX);
        else if (mul_result < 0)
            b_new = '0;
        else
            b_new = 31'(mul_result);
        f2_new = (mul_result <= 0) ? word_t'(1) : mul_result;
        an_w   = div_result - ONE;
        if (an_w > RES_MAX)
            a_new = 32'(RES_MAX);
        else if (an_w < RES_MIN)
            a_new = 32'(RES_MIN);
        else
            a_new = 32'(an_w);
    end

    rsq_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .op_p   (mul_p),
        .op_q   (mul_q),
        .done   (mul_done),
        .result (mul_result)
    );

    rsq_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .result (div_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_count_reg <= CFG_W'(4);
        else if (cfg_write_enable)
            cfg_count_reg <= cfg_write_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            a_reg     <= in_data.x_value;
            b_reg     <= 31'(ONE);
            cubic_reg <= in_data.degree_select;
            n_reg     <= n_clamped;
            k_reg     <= '0;
        end
        if (cmd.iter_next)
            k_reg <= k_reg + 1'b1;
        if (cmd.lat_a2)
            a2_reg <= mul_result;
        if (cmd.lat_a3)
            a3_reg <= mul_result;
        if (cmd.lat_fac)
        begin
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            d1_reg <= d1_next;
            d2_reg <= d2_next;
        end
        if (cmd.lat_f)
            f_reg <= div_result;
        if (cmd.lat_b)
            b_reg <= b_new;
        if (cmd.lat_f2)
            f2_reg <= f2_new;
        if (cmd.lat_a)
            a_reg <= a_new;
        if (cmd.out_load)
        begin
            out_reg.iteration_index <= 3'(k_reg);
            out_reg.approximation   <= b_reg;
            out_reg.residual        <= a_reg;
            out_reg.last_result     <= status.last;
            out_reg.domain_error    <= 1'b0;
        end
        else if (cmd.out_error)
        begin
            out_reg.iteration_index <= '0;
            out_reg.approximation   <= '0;
            out_reg.residual        <= '0;
            out_reg.last_result     <= 1'b1;
            out_reg.domain_error    <= 1'b1;
        end
    end

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign status.x_error  = word_t'(in_data.x_value) <= -ONE;
    assign status.cubic    = cubic_reg;
    assign status.last     = k_reg == ITER_W'(n_reg - 1'b1);
    assign out_data        = out_reg;

endmodule

@@ hw/rtl/rsq_controller.sv @@
// ----------------------------------------------------------------------------
// Rational square root controller
// Sequences the multiplies and divisions of each iteration and manages
// both handshakes.
// ----------------------------------------------------------------------------
`include "rational_iterative_sqrt_one_plus_x_defines.svh"

module rsq_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  rsq_pkg::status_t status,
    output rsq_pkg::cmd_t    cmd
);
    import rsq_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ITER   = 5'd1;
    localparam logic [4:0] S_MA2_GO = 5'd2;
    localparam logic [4:0] S_MA2_W  = 5'd3;
    localparam logic [4:0] S_MA3_GO = 5'd4;
    localparam logic [4:0] S_MA3_W  = 5'd5;
    localparam logic [4:0] S_FAC1   = 5'd6;
    localparam logic [4:0] S_FAC2   = 5'd7;
    localparam logic [4:0] S_DF_W   = 5'd8;
    localparam logic [4:0] S_MB_GO  = 5'd9;
    localparam logic [4:0] S_MB_W   = 5'd10;
    localparam logic [4:0] S_MF_GO  = 5'd11;
    localparam logic [4:0] S_MF_W   = 5'd12;
    localparam logic [4:0] S_DS_GO  = 5'd13;
    localparam logic [4:0] S_DS_W   = 5'd14;
    localparam logic [4:0] S_OUT    = 5'd15;
    localparam logic [4:0] S_ERR    = 5'd16;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = status.x_error ? S_ERR : S_ITER;
                end
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    cmd.out_error = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ITER:
                state_next = status.cubic ? S_MA2_GO : S_FAC1;
            S_MA2_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SEL_AA;
                state_next    = S_MA2_W;
            end
            S_MA2_W:
            begin
                if (status.mul_done)
                begin
                    cmd.lat_a2 = 1'b1;
                    state_next = S_MA3_GO;
                end
            end
            S_MA3_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SEL_A2A;
                state_next    = S_MA3_W;
            end
            S_MA3_W:
            begin
                if (status.mul_done)
                begin
                    cmd.lat_a3 = 1'b1;
                    state_next = S_FAC1;
                end
            end
            S_FAC1:
            begin
                cmd.lat_fac = 1'b1;
                state_next  = S_FAC2;
            end
            S_FAC2:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_FACT;
                state_next    = S_DF_W;
            end
            S_DF_W:
            begin
                if (status.div_done)
                begin
                    cmd.lat_f  = 1'b1;
                    state_next = S_MB_GO;
                end
            end
            S_MB_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SEL_BF;
                state_next    = S_MB_W;
            end
            S_MB_W:
            begin
                if (status.mul_done)
                begin
                    cmd.lat_b  = 1'b1;
                    state_next = S_MF_GO;
                end
            end
            S_MF_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SEL_FF;
                state_next    = S_MF_W;
            end
            S_MF_W:
            begin
                if (status.mul_done)
                begin
                    cmd.lat_f2 = 1'b1;
                    state_next = S_DS_GO;
                end
            end
            S_DS_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_S;
                state_next    = S_DS_W;
            end
            S_DS_W:
            begin
                cmd.div_sel = DIV_SEL_S;
                if (status.div_done)
                begin
                    cmd.lat_a  = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.iter_next = 1'b1;
                        state_next    = S_ITER;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load || cmd.out_error)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `RSQ_ASSERT_SAME(a_load_slot, cmd.out_load || cmd.out_error, !out_valid_reg || out_ready)
    `RSQ_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == S_ITER || state_reg == S_ERR)
    `RSQ_ASSERT_SAME(a_mul_done_wait, status.mul_done, state_reg == S_MA2_W || state_reg == S_MA3_W || state_reg == S_MB_W || state_reg == S_MF_W)
    `RSQ_ASSERT_SAME(a_div_done_wait, status.div_done, state_reg == S_DF_W || state_reg == S_DS_W)

endmodule

@@ hw/rtl/rational_iterative_sqrt_one_plus_x.sv @@
// ----------------------------------------------------------------------------
// Rational iterative square root of one plus x
// Each iteration takes longer with the third-degree factor; its time is set
// mostly by the two divisions on the shared restoring divider.
// The next item is accepted once its last result sits in the output register.
// Reset is asynchronous, active low, and sets the iteration count to four.
// ----------------------------------------------------------------------------
module rational_iterative_sqrt_one_plus_x (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_enable,
    input  logic [3:0]    cfg_write_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  rsq_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rsq_pkg::out_t out_data
);
    import rsq_pkg::*;

    cmd_t    cmd;
    status_t status;

    rsq_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rsq_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_data          (in_data),
        .cmd              (cmd),
        .status           (status),
        .out_data         (out_data)
    );

endmodule

@@ sim/rational_iterative_sqrt_one_plus_x_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the rational square root of one plus x
// Values of x and a degree choice are sent to the block and every beat that
// comes back is compared with an own fixed-point model of the iteration. The
// iteration count is changed between phases, and both sides idle at random.
// ----------------------------------------------------------------------------
module rational_iterative_sqrt_one_plus_x_test;

    import rsq_pkg::*;

    localparam longint LIM      = 64'sd1 <<< 61;
    localparam longint UNIT     = 64'sd1 <<< FRAC_BITS;
    localparam int     WD_LIMIT = 20000;
    localparam int     DEG_LINEAR = 0;
    localparam int     DEG_CUBIC  = 1;

    logic       clk;
    logic       rst_n;
    logic       cfg_write_enable;
    logic [3:0] cfg_write_data;
    logic       in_valid;
    logic       in_ready;
    in_t        in_data;
    logic       out_valid;
    logic       out_ready;
    out_t       out_data;

    in_t    pending_items[$];
    out_t   expected_beats[$];
    int     errors;
    int     sender_idle_pct;
    int     receiver_stall_pct;
    int     hold_off_cycles;
    int     idle_cycles;
    logic   in_taken;
    logic [3:0] iter_setting;

    rational_iterative_sqrt_one_plus_x u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint fx_mul(longint p, longint q);
        logic           neg;
        logic [63:0]    up;
        logic [63:0]    uq;
        logic [127:0]   prod;
        logic [127:0]   res;
        neg  = (p < 0) != (q < 0);
        up   = p < 0 ? -p : p;
        uq   = q < 0 ? -q : q;
        prod = up * uq + (128'd1 << (FRAC_BITS - 1));
        res  = prod >> FRAC_BITS;
        if (res > LIM)
            res = LIM;
        return neg ? -longint'(res) : longint'(res);
    endfunction

    function automatic longint fx_scale(longint v, longint c);
        if (v > LIM / c)
            return LIM;
        if (v < -(LIM / c))
            return -LIM;
        return v * c;
    endfunction

    function automatic longint fx_add(longint p, longint q);
        longint s;
        s = p + q;
        if (s > LIM)
            return LIM;
        if (s < -LIM)
            return -LIM;
        return s;
    endfunction

    function automatic longint fx_div(longint n, longint d);
        logic [127:0] q;
        if (n / d > (LIM >>> FRAC_BITS))
            return LIM;
        q = ((128'(n) << (FRAC_BITS + 1)) / d + 1) >> 1;
        if (q > LIM)
            return LIM;
        return longint'(q);
    endfunction

    function automatic longint factor_of(longint a, logic cubic);
        longint a2;
        longint a3;
        longint num;
        longint den;
        if (cubic)
        begin
            a2  = fx_mul(a, a);
            a3  = fx_mul(a2, a);
            num = fx_add(fx_add(fx_scale(a3, 7), fx_scale(a2, 56)),
                         fx_add(fx_scale(a, 112), fx_scale(UNIT, 64)));
            den = fx_add(fx_add(a3, fx_scale(a2, 24)),
                         fx_add(fx_scale(a, 80), fx_scale(UNIT, 64)));
        end
        else
        begin
            num = fx_add(fx_scale(a, 3), fx_scale(UNIT, 4));
            den = fx_add(a, fx_scale(UNIT, 4));
        end
        if (num < 0)
            num = 0;
        if (den <= 0)
            den = 1;
        return fx_div(num, den);
    endfunction

    task automatic predict_sqrt(input in_t item);
        longint x;
        longint prod;
        longint a;
        longint f;
        longint f2;
        longint s;
        int     n;
        out_t   beat;
        x = longint'(item.x_value);
        if (x <= -UNIT)
        begin
            beat = '0;
            beat.last_result  = 1'b1;
            beat.domain_error = 1'b1;
            expected_beats.push_back(beat);
            return;
        end
        n = int'(iter_setting);
        if (n < 1)
            n = 1;
        if (n > MAX_ITERATIONS)
            n = MAX_ITERATIONS;
        prod = UNIT;
        a    = x;
        for (int k = 0; k < n; k++)
        begin
            f    = factor_of(a, item.degree_select);
            prod = fx_mul(prod, f);
            if (prod > 64'sd2147483647)
                prod = 64'sd2147483647;
            if (prod < 0)
                prod = 0;
            f2 = fx_mul(f, f);
            if (f2 <= 0)
                f2 = 1;
            s = UNIT + a;
            if (s < 0)
                s = 0;
            a = fx_div(s, f2) - UNIT;
            if (a > 64'sd2147483647)
                a = 64'sd2147483647;
            if (a < -64'sd2147483648)
                a = -64'sd2147483648;
            beat.iteration_index = k[2:0];
            beat.approximation   = prod[30:0];
            beat.residual        = a[31:0];
            beat.last_result     = (k == n - 1);
            beat.domain_error    = 1'b0;
            expected_beats.push_back(beat);
        end
    endtask

    task automatic report_mismatch(input string what, input out_t got, input out_t want);
        errors++;
        $display("mismatch in %s: got %h, expected %h", what, got, want);
    endtask

    // Driver: the payload is held until the beat is accepted.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= $urandom_range(99) >= receiver_stall_pct;
        end
    end

    // Monitor: predictions are made at acceptance, results checked in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && in_ready)
                predict_sqrt(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch("unexpected beat", out_data, '0);
                else
                begin
                    out_t want;
                    want = expected_beats.pop_front();
                    if (out_data !== want)
                        report_mismatch("result beat", out_data, want);
                end
            end
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("rational_iterative_sqrt_one_plus_x_test NOT OK");
                $finish;
            end
        end
    end

    function automatic in_t random_item();
        in_t item;
        int  pick;
        pick = $urandom_range(9);
        if (pick < 6)
            item.x_value = $signed($urandom_range(32'h7FFFFFF)) - 32'sd16777215;
        else if (pick < 8)
            item.x_value = $urandom_range(32'h7FFFFFFF);
        else
            item.x_value = $urandom;
        item.degree_select = 1'($urandom_range(1));
        return item;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || expected_beats.size() > 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    task automatic write_iterations(input logic [3:0] value);
        @(negedge clk);
        cfg_write_enable = 1'b1;
        cfg_write_data   = value;
        iter_setting     = value;
        @(negedge clk);
        cfg_write_enable = 1'b0;
    endtask

    task automatic queue_random(input int count);
        repeat (count) pending_items.push_back(random_item());
    endtask

    initial
    begin
        in_t         item;
        logic [31:0] directed_x[10];
        errors             = 0;
        idle_cycles        = 0;
        in_taken           = 1'b0;
        hold_off_cycles    = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        iter_setting       = 4'd4;
        rst_n              = 1'b0;
        cfg_write_enable   = 1'b0;
        cfg_write_data     = '0;
        in_valid           = 1'b0;
        in_data            = '0;
        out_ready          = 1'b0;
        directed_x = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFF000000, 32'hFF000001,
                       32'hFEFFFFFF, 32'h01000000, 32'hFFFFFFFF, 32'h00000001,
                       32'h55AAAA55};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_x[i])
            for (int d = DEG_LINEAR; d <= DEG_CUBIC; d++)
            begin
                item.x_value       = directed_x[i];
                item.degree_select = 1'(d);
                pending_items.push_back(item);
            end
        wait_drained();

        write_iterations(4'd1);
        queue_random(60);
        wait_drained();

        write_iterations(4'd8);
        sender_idle_pct = 68;
        queue_random(50);
        wait_drained();

        write_iterations(4'd0);
        sender_idle_pct    = 0;
        receiver_stall_pct = 68;
        queue_random(60);
        wait_drained();

        write_iterations(4'd15);
        sender_idle_pct = 31;
        queue_random(40);
        wait_drained();

        write_iterations(4'd3);
        receiver_stall_pct = 31;
        hold_off_cycles    = 3000;
        queue_random(120);
        wait_drained();

        write_iterations(4'd2);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        queue_random(120);
        wait_drained();

        if (errors == 0)
            $display("rational_iterative_sqrt_one_plus_x_test OK");
        else
            $display("rational_iterative_sqrt_one_plus_x_test NOT OK");
        $finish;
    end

endmodule
